FILE: hdl/itd_pkg.sv
package itd_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] value;
  } itd_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [4:0] char_count;
    logic       last;
  } itd_out_t;

  // control shared by every digit cell
  typedef struct packed {
    logic clr;
    logic shift_bit;
    logic shift_dig;
    logic dec;
  } itd_cell_ctl_t;

  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEXL = 2'd2;
  localparam logic [1:0] CMD_HEXU = 2'd3;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic [4:0] MAX_CHARS = 5'd20;

  function automatic logic [7:0] itd_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d8;
    end else if (upper) begin
      return CHAR_UPPER_A + d8 - 8'd10;
    end else begin
      return CHAR_LOWER_A + d8 - 8'd10;
    end
  endfunction

endpackage

FILE: hdl/itd_cell.sv
module itd_cell
  import itd_pkg::*;
(
  input  logic          clk,
  input  itd_cell_ctl_t ctl,
  input  logic          bit_in,
  input  logic [3:0]    dig_in,
  output logic          bit_out,
  output logic [3:0]    digit
);

  logic [3:0] dig_r;
  logic [3:0] corr;

  // add-3 correction before each doubling in decimal mode
  assign corr    = (ctl.dec && dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
  assign bit_out = corr[3];
  assign digit   = dig_r;

  always_ff @(posedge clk) begin
    priority if (ctl.clr) begin
      dig_r <= 4'd0;
    end else if (ctl.shift_bit) begin
      dig_r <= {corr[2:0], bit_in};
    end else if (ctl.shift_dig) begin
      dig_r <= dig_in;
    end else begin
      dig_r <= dig_r;
    end
  end

endmodule

FILE: hdl/integer_to_ascii_digits.sv
// Converts one binary word per request into ASCII text, one character per
// output request, most significant digit first without leading zeros. cmd
// selects signed decimal, unsigned decimal, lowercase hex or uppercase hex.
// The word is shifted bit by bit into a row of 4-bit digit cells (add-3
// correction in decimal): a request is loaded, then VALUE_BITS bits are
// shifted in decimal or HEX_BITS in hex, leading zero cells are skipped,
// and then one character is emitted per cycle while out_ready is high (a
// minus sign first for a negative signed value). A new request is taken
// only when the last character is registered.
module integer_to_ascii_digits
  import itd_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int HEX_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  itd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output itd_out_t out_data
);

  localparam int SW         = (VALUE_BITS > HEX_BITS) ? VALUE_BITS : HEX_BITS;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (HEX_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int CW         = $clog2(SW + 1);
  localparam int RW         = $clog2(NDIG + 1);

  typedef enum logic [1:0] {IDLE, CONV, SKIP, EMIT} state_t;

  state_t        state_r;
  logic [SW-1:0] sreg_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] rem_r;
  logic [4:0]    count_r;
  logic          dec_r;
  logic          upper_r;
  logic          sign_r;
  logic          out_valid_r;
  itd_out_t      out_r;

  logic [VALUE_BITS-1:0] vbits;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  is_dec;
  logic [SW-1:0]         load_val;
  logic                  out_free;
  logic                  skip;
  logic [3:0]            top_dig;
  itd_cell_ctl_t         ctl;

  logic       bit_link [NDIG+1];
  logic [3:0] dig_link [NDIG+1];

  assign vbits    = in_data.value[VALUE_BITS-1:0];
  assign is_dec   = (in_data.cmd == CMD_SDEC) || (in_data.cmd == CMD_UDEC);
  assign neg      = (in_data.cmd == CMD_SDEC) && vbits[VALUE_BITS-1];
  // unsigned negate so the most negative value keeps its magnitude
  assign mag      = neg ? VALUE_BITS'(~vbits + 1'b1) : vbits;
  assign load_val = is_dec ? (SW'(mag) << (SW - VALUE_BITS))
                           : (SW'(in_data.value[HEX_BITS-1:0]) << (SW - HEX_BITS));

  assign top_dig  = dig_link[NDIG];
  assign out_free = !out_valid_r || out_ready;
  assign skip     = (top_dig == 4'd0) && (rem_r > RW'(1));

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ctl.clr       = (state_r == IDLE) && in_valid;
    ctl.shift_bit = (state_r == CONV);
    ctl.shift_dig = ((state_r == SKIP) && skip) ||
                    ((state_r == EMIT) && out_free && !sign_r);
    ctl.dec       = dec_r;
  end

  assign bit_link[0] = sreg_r[SW-1];
  assign dig_link[0] = 4'd0;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    itd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .bit_in  (bit_link[i]),
      .dig_in  (dig_link[i]),
      .bit_out (bit_link[i+1]),
      .digit   (dig_link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            state_r <= CONV;
            sreg_r  <= load_val;
            cnt_r   <= is_dec ? CW'(VALUE_BITS) : CW'(HEX_BITS);
            rem_r   <= RW'(NDIG);
            count_r <= 5'd0;
            dec_r   <= is_dec;
            upper_r <= (in_data.cmd == CMD_HEXU);
            sign_r  <= neg;
          end
        end
        CONV: begin
          sreg_r <= sreg_r << 1;
          cnt_r  <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= SKIP;
          end
        end
        SKIP: begin
          if (skip) begin
            rem_r <= rem_r - RW'(1);
          end else begin
            state_r <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            count_r          <= count_r + 5'd1;
            out_r.char_count <= count_r + 5'd1;
            if (sign_r) begin
              out_r.char_code <= CHAR_MINUS;
              out_r.last      <= 1'b0;
              sign_r          <= 1'b0;
            end else begin
              out_r.char_code <= itd_char(top_dig, upper_r);
              out_r.last      <= (rem_r == RW'(1));
              rem_r           <= rem_r - RW'(1);
              if (rem_r == RW'(1)) begin
                state_r <= IDLE;
              end
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/itd_checker.sv
module itd_checker
  import itd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input itd_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input itd_out_t out_data
);

  logic       prev_last_r;
  logic [4:0] prev_cnt_r;
  logic       out_acc;
  logic       in_acc;

  assign out_acc = out_valid && out_ready;
  assign in_acc  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_last_r <= 1'b1;
      prev_cnt_r  <= 5'd0;
    end else if (out_acc) begin
      prev_last_r <= out_data.last;
      prev_cnt_r  <= out_data.char_count;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // count restarts at one after a last character, else steps by one
  a_count_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (prev_last_r ? (out_data.char_count == 5'd1)
                             : (out_data.char_count == prev_cnt_r + 5'd1)))
    else $error("character count out of sequence");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.char_count != 5'd0) && (out_data.char_count <= MAX_CHARS))
    else $error("character count out of range");

  // no new request while a number's text is unfinished
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while busy");

  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> prev_last_r || (out_valid && out_data.last))
    else $error("ready before final character");

endmodule

bind integer_to_ascii_digits itd_checker u_itd_checker (.*);
